FILE: src/utf8_to_utf16_transcoder_defines.svh
// Assertion macros for the UTF-8 to UTF-16 transcoder.
// No dependencies; included by the checker module.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Same-cycle implication, gated by a disable condition.
`define U8U16_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated by a disable condition.
`define U8U16_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/u8u16_pkg.sv
// Shared types, constants and the lead-byte classifier for the transcoder.
// No dependencies.
package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam int          Q_DEPTH      = 2;

  // Bytes of one decode job, lead byte in slot 0; n is 1..4 valid bytes.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            fin;
  } job_t;

  // Sequence length from a lead byte; 0 for a stray byte.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (!b[7])                   len = 3'd1;
    else if (b[7:5] == 3'b110)   len = 3'd2;
    else if (b[7:4] == 4'b1110)  len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    return len;
  endfunction

endpackage

FILE: src/u8u16_if.sv
// Valid/ready channel interfaces: byte input and UTF-16 unit output.
// No dependencies.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_of_run;
  logic        string_done;

  modport source (output valid, output code_unit, output last_of_run, output string_done,
                  input ready);
  modport sink   (input valid, input code_unit, input last_of_run, input string_done,
                  output ready);
endinterface

FILE: src/u8u16_front.sv
// Front end: collects bytes of an open sequence and issues decode jobs.
// Depends on u8u16_pkg and u8u16_in_if.
module u8u16_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  u8u16_in_if.sink          byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output u8u16_pkg::job_t   job_o
);
  import u8u16_pkg::*;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [2:0]      seq_len_q, seq_len_d;

  logic [3:0][7:0] buf_bytes;
  logic [2:0]      n_cnt;
  logic [2:0]      open_len;
  logic            hold;
  logic            accept;

  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    n_cnt     = {1'b0, held_cnt_q} + 3'd1;
    buf_bytes = '0;
    for (int j = 0; j < 3; j++) begin
      if (j < int'(held_cnt_q)) buf_bytes[j] = held_q[j];
    end
    buf_bytes[held_cnt_q] = byte_i.data_byte;
    open_len = (held_cnt_q == 2'd0) ? seq_len(byte_i.data_byte) : seq_len_q;
    // keep collecting while the sequence is short and the string goes on
    hold = !byte_i.end_of_string && (open_len > n_cnt);
  end

  always_comb begin
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    seq_len_d  = seq_len_q;
    if (accept) begin
      if (hold) begin
        held_d     = buf_bytes[2:0];
        held_cnt_d = n_cnt[1:0];
        seq_len_d  = open_len;
      end else begin
        held_d     = '0;
        held_cnt_d = '0;
        seq_len_d  = '0;
      end
    end
  end

  assign push_o    = accept && !hold;
  assign job_o     = '{bytes: buf_bytes, n: n_cnt, fin: byte_i.end_of_string};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      held_cnt_q <= '0;
      seq_len_q  <= '0;
    end else begin
      held_q     <= held_d;
      held_cnt_q <= held_cnt_d;
      seq_len_q  <= seq_len_d;
    end
  end

endmodule

FILE: src/u8u16_queue.sv
// Small job queue between front end and back end.
// Depends on u8u16_pkg.
module u8u16_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8u16_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            avail_o,
  output u8u16_pkg::job_t job_o
);
  import u8u16_pkg::*;

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CntW = $clog2(Q_DEPTH + 1);

  job_t            mem_q [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Q_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Q_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/u8u16_back.sv
// Back end: decodes one sequence or surrogate half per step, emits UTF-16 units through
// an output register. Depends on u8u16_pkg and u8u16_out_if.
module u8u16_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  u8u16_pkg::job_t job_i,
  input  logic            job_avail_i,
  output logic            pop_o,
  u8u16_out_if.source     unit_o
);
  import u8u16_pkg::*;

  job_t        job_q, job_shift;
  logic        job_valid_q;
  logic        lo_pend_q;

  logic        out_valid_q;
  logic [15:0] unit_q;
  logic        last_q, done_q;

  logic [2:0]  len, consume, n_left;
  logic        trunc, is_pair, step_done, last;
  logic [20:0] cp, v;
  logic [15:0] unit_d;
  logic        advance, finish;

  always_comb begin
    len   = seq_len(job_q.bytes[0]);
    trunc = (len == 3'd0) || (len > job_q.n);
    case (len)
      3'd1:    cp = {13'd0, job_q.bytes[0]};
      3'd2:    cp = {10'd0, job_q.bytes[0][4:0], job_q.bytes[1][5:0]};
      3'd3:    cp = {5'd0, job_q.bytes[0][3:0], job_q.bytes[1][5:0], job_q.bytes[2][5:0]};
      3'd4:    cp = {job_q.bytes[0][2:0], job_q.bytes[1][5:0], job_q.bytes[2][5:0],
                     job_q.bytes[3][5:0]};
      default: cp = '0;
    endcase
    v         = cp - SUPP_BASE;
    is_pair   = !trunc && (cp[20:16] != 5'd0);
    step_done = trunc || !is_pair || lo_pend_q;
    consume   = trunc ? 3'd1 : len;
    n_left    = job_q.n - consume;
    last      = step_done && (n_left == 3'd0);

    if (trunc)          unit_d = REPL_UNIT;
    else if (lo_pend_q) unit_d = LO_SURR_BASE | {6'd0, v[9:0]};
    else if (is_pair)   unit_d = HI_SURR_BASE | {5'd0, v[20:10]};
    else                unit_d = cp[15:0];

    job_shift       = job_q;
    job_shift.bytes = job_q.bytes >> {consume, 3'b000};
    job_shift.n     = n_left;
  end

  assign advance = job_valid_q && (!out_valid_q || unit_o.ready);
  assign finish  = advance && last;
  assign pop_o   = job_avail_i && (!job_valid_q || finish);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end else if (advance && step_done) begin
      job_q <= job_shift;
    end
    if (advance) begin
      unit_q <= unit_d;
      last_q <= last;
      done_q <= last && job_q.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      lo_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o)       job_valid_q <= 1'b1;
      else if (finish) job_valid_q <= 1'b0;

      if (pop_o)        lo_pend_q <= 1'b0;
      else if (advance) lo_pend_q <= !step_done;

      if (advance)           out_valid_q <= 1'b1;
      else if (unit_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign unit_o.valid       = out_valid_q;
  assign unit_o.code_unit   = unit_q;
  assign unit_o.last_of_run = last_q;
  assign unit_o.string_done = done_q;

endmodule

FILE: src/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder, top level.
// Byte input channel (byte_i): one UTF-8 byte per beat plus end_of_string.
// Unit output channel (unit_o): one UTF-16 code unit per beat, with
//   last_of_run on the final unit caused by a byte and string_done on the
//   final unit of the string.
// Throughput: one byte per cycle sustained while the output is not stalled.
//   Each output unit takes one step of the back-end decoder; a byte that yields
//   two or three units (surrogate pair, truncated sequence at end of string)
//   holds the decoder that long, and the two-entry job queue absorbs that burst
//   before input ready drops. Path from the input beat that completes a sequence
//   to the first unit being valid: queue, decoder job register, output register.
// Bytes that only extend an open sequence produce no unit and no job.
// Reset (rst_ni low, async) empties the queue, the decoder and the output
//   register and drops any partially collected sequence.
// Output stall: the unit is held in the output register; the decoder and
//   queue fill behind it, then byte_i.ready falls until the sink takes beats.
// Depends on u8u16_pkg, u8u16_if, u8u16_front, u8u16_queue, u8u16_back.
module utf8_to_utf16_transcoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8u16_in_if.sink     byte_i,
  u8u16_out_if.source  unit_o
);
  import u8u16_pkg::*;

  // front end -> queue
  logic push;
  job_t push_job;
  // queue -> back end
  logic q_full, q_avail, pop;
  job_t head_job;

  // Front end: assembles multi-byte sequences, issues complete jobs.
  u8u16_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Decouples byte intake from unit emission.
  u8u16_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .avail_o (q_avail),
    .job_o   (head_job)
  );

  // Back end: walks a job one sequence (or surrogate half) per cycle while the output is not stalled.
  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_avail_i (q_avail),
    .pop_o       (pop),
    .unit_o      (unit_o)
  );

endmodule

FILE: src/u8u16_checker.sv
// Port-level assertions for the transcoder, bound to the top level.
// Depends on utf8_to_utf16_transcoder_defines.svh.
`include "utf8_to_utf16_transcoder_defines.svh"

module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] code_unit_i,
  input logic        last_of_run_i,
  input logic        string_done_i
);

  logic out_beat;
  assign out_beat = out_valid_i && out_ready_i;

  `U8U16_ASSERT_NXT(a_stall_hold, clk_i, !rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(code_unit_i) && $stable(last_of_run_i) && $stable(string_done_i), "stalled unit changed")
  `U8U16_ASSERT_NOW(a_done_is_last, clk_i, !rst_ni, out_valid_i && string_done_i, last_of_run_i, "string_done without last_of_run")
  `U8U16_ASSERT_NXT(a_run_continues, clk_i, !rst_ni, out_beat && !last_of_run_i, out_valid_i, "gap inside a run of units")
  `U8U16_ASSERT_NOW(a_reset_idle, clk_i, 1'b0, !rst_ni, !out_valid_i, "output valid during reset")

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (unit_o.valid),
  .out_ready_i   (unit_o.ready),
  .code_unit_i   (unit_o.code_unit),
  .last_of_run_i (unit_o.last_of_run),
  .string_done_i (unit_o.string_done)
);

FILE: tb/u8u16_scoreboard_pkg.sv
// Scoreboard for the UTF-8 to UTF-16 transcoder testbench: predicts code units
// per accepted byte and checks output beats in order. Depends on u8u16_pkg.
package u8u16_scoreboard_pkg;

  import u8u16_pkg::REPL_UNIT;
  import u8u16_pkg::SUPP_BASE;
  import u8u16_pkg::HI_SURR_BASE;
  import u8u16_pkg::LO_SURR_BASE;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_run;
    logic        string_done;
  } unit_t;

  class u8u16_scoreboard;
    // decoder state, mirrored from the block
    logic [7:0]  held [3];
    logic [1:0]  held_cnt;
    logic [2:0]  open_len;
    unit_t       units_q [$];
    int          errors;
    int          units_checked;
    int          strings_ended;
    int          pairs_made;
    int          repl_made;

    function new();
      held          = '{default: 8'h00};
      held_cnt      = '0;
      open_len      = '0;
      errors        = 0;
      units_checked = 0;
      strings_ended = 0;
      pairs_made    = 0;
      repl_made     = 0;
    endfunction

    // 0 marks a stray byte
    function int unsigned lead_length(logic [7:0] b);
      if (b[7] == 1'b0)        return 1;
      if (b[7:5] == 3'b110)    return 2;
      if (b[7:4] == 4'b1110)   return 3;
      if (b[7:3] == 5'b11110)  return 4;
      return 0;
    endfunction

    function void push_unit(logic [15:0] cu);
      unit_t u;
      u.code_unit   = cu;
      u.last_of_run = 1'b0;
      u.string_done = 1'b0;
      units_q.push_back(u);
    endfunction

    // Accepted input beat: work out the units it causes.
    function void note_byte(logic [7:0] data, logic eos);
      logic [7:0]  seq [4];
      int unsigned n, i, j, len;
      logic [20:0] cp;
      logic [20:0] off;
      int          first;
      n = 32'(held_cnt);
      for (j = 0; j < n; j++) seq[j] = held[j];
      seq[n] = data;
      n++;
      held     = '{default: 8'h00};
      held_cnt = '0;
      open_len = '0;
      first    = units_q.size();
      i = 0;
      while (i < n) begin
        len = lead_length(seq[i]);
        if (len == 0 || (i + len > n && eos)) begin
          // stray byte, or a lead cut off by end of string: rest is rescanned
          push_unit(REPL_UNIT);
          repl_made++;
          i++;
        end else if (i + len > n) begin
          for (j = 0; i + j < n && j < 3; j++) held[j] = seq[i + j];
          held_cnt = j[1:0];
          open_len = len[2:0];
          break;
        end else begin
          case (len)
            1:       cp = {13'b0, seq[i]};
            2:       cp = {10'b0, seq[i][4:0], seq[i+1][5:0]};
            3:       cp = {5'b0, seq[i][3:0], seq[i+1][5:0], seq[i+2][5:0]};
            default: cp = {seq[i][2:0], seq[i+1][5:0], seq[i+2][5:0], seq[i+3][5:0]};
          endcase
          if (cp < SUPP_BASE) begin
            push_unit(cp[15:0]);
          end else begin
            off = cp - SUPP_BASE;
            push_unit(HI_SURR_BASE | {5'b0, off[20:10]});
            push_unit(LO_SURR_BASE | {6'b0, off[9:0]});
            pairs_made++;
          end
          i += len;
        end
      end
      if (units_q.size() > first) begin
        units_q[units_q.size() - 1].last_of_run = 1'b1;
        units_q[units_q.size() - 1].string_done = eos;
      end
      if (eos) strings_ended++;
    endfunction

    // Accepted output beat: compare with the oldest expected unit.
    function void check_unit(unit_t got);
      unit_t want;
      units_checked++;
      if (units_q.size() == 0) begin
        errors++;
        $display("%0t: expected no unit, got unit=%h last=%b done=%b",
                 $time, got.code_unit, got.last_of_run, got.string_done);
        return;
      end
      want = units_q.pop_front();
      if (want.code_unit != got.code_unit || want.last_of_run != got.last_of_run ||
          want.string_done != got.string_done) begin
        errors++;
        $display("%0t: expected unit=%h last=%b done=%b, got unit=%h last=%b done=%b",
                 $time, want.code_unit, want.last_of_run, want.string_done,
                 got.code_unit, got.last_of_run, got.string_done);
      end
    endfunction

    function int pending();
      return units_q.size();
    endfunction
  endclass

endpackage

FILE: tb/utf8_to_utf16_transcoder_tb.sv
// Top-level testbench for utf8_to_utf16_transcoder: drives bytes, drains units.
// Depends on u8u16_pkg, u8u16_if, u8u16_scoreboard_pkg and the block itself.
module utf8_to_utf16_transcoder_tb;
  import u8u16_scoreboard_pkg::*;

  typedef enum int {
    SEQ_ASCII,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_FOUR,
    SEQ_STRAY,
    SEQ_BROKEN
  } seq_kind_e;

  // Items past which the random part stops; hold-off on the sink side.
  localparam int ITEM_TARGET   = 425;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 24;

  logic clk_i  = 1'b0;
  logic rst_ni;

  // calm = 1: neither side inserts random gaps (the one sink hold-off still applies)
  bit calm = 1'b0;
  int items_sent = 0;

  u8u16_in_if  byte_if ();
  u8u16_out_if unit_if ();

  u8u16_scoreboard sb = new();

  utf8_to_utf16_transcoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .unit_o (unit_if)
  );

  always #6 clk_i = ~clk_i;

  // Gap lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One input beat. valid is only lowered when a gap precedes this beat, so a
  // back-to-back beat never sees a low and a high in the same step.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid         <= 1'b1;
    byte_if.data_byte     <= b;
    byte_if.end_of_string <= eos;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    // beat taken at this edge; values sampled are the pre-edge ones
    sb.note_byte(b, eos);
    items_sent++;
  endtask

  function automatic logic rand_eos();
    return ($urandom_range(0, 15) == 0);
  endfunction

  // Continuation byte: usually well formed, sometimes any value at all,
  // since the block takes whatever follows a lead unchecked.
  function automatic logic [7:0] cont_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) != 0) b[7:6] = 2'b10;
    return b;
  endfunction

  // Edges of the byte space, every sequence length, truncation at end of
  // string (with a rescanned tail), an ASCII byte and a lead held as
  // continuations, and a lone lead at end of string.
  task automatic run_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hD0, 1'b1);
  endtask

  function automatic seq_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SEQ_ASCII;
    if (r < 55) return SEQ_TWO;
    if (r < 70) return SEQ_THREE;
    if (r < 85) return SEQ_FOUR;
    if (r < 93) return SEQ_STRAY;
    return SEQ_BROKEN;
  endfunction

  // One random sequence; end of string may land anywhere inside it.
  task automatic send_sequence();
    seq_kind_e   kind;
    logic [7:0]  lead;
    int unsigned len, k, n_cont;
    kind = pick_kind();
    lead = 8'($urandom_range(0, 255));
    case (kind)
      SEQ_ASCII: begin
        lead[7] = 1'b0;
        len = 1;
      end
      SEQ_TWO: begin
        lead[7:5] = 3'b110;
        len = 2;
      end
      SEQ_THREE: begin
        lead[7:4] = 4'b1110;
        len = 3;
      end
      SEQ_FOUR: begin
        lead[7:3] = 5'b11110;
        len = 4;
      end
      SEQ_STRAY: begin
        if ($urandom_range(0, 1) == 0) lead[7:6] = 2'b10;
        else lead[7:3] = 5'b11111;
        len = 1;
      end
      default: begin
        // lead with too few followers; the next sequence gets absorbed
        len = $urandom_range(2, 4);
        lead = (len == 2) ? {3'b110, lead[4:0]} :
               (len == 3) ? {4'b1110, lead[3:0]} : {5'b11110, lead[2:0]};
      end
    endcase
    n_cont = (kind == SEQ_BROKEN) ? $urandom_range(0, len - 2) : len - 1;
    send_byte(lead, rand_eos());
    for (k = 0; k < n_cont; k++) send_byte(cont_byte(), rand_eos());
  endtask

  // Output side: random ready, plus one long hold-off after some traffic so
  // the queue fills and byte_if.ready drops while the sender keeps offering.
  initial begin : unit_sink
    int    idle_left;
    int    units_taken;
    bit    held_off;
    unit_t got;
    idle_left   = 0;
    units_taken = 0;
    held_off    = 1'b0;
    unit_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (unit_if.valid && unit_if.ready) begin
        got.code_unit   = unit_if.code_unit;
        got.last_of_run = unit_if.last_of_run;
        got.string_done = unit_if.string_done;
        sb.check_unit(got);
        units_taken++;
      end
      if (!held_off && units_taken >= HOLD_AFTER) begin
        held_off  = 1'b1;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left > 0) begin
        unit_if.ready <= 1'b0;
        idle_left--;
      end else begin
        unit_if.ready <= 1'b1;
        idle_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    byte_if.valid         <= 1'b0;
    byte_if.data_byte     <= 8'h00;
    byte_if.end_of_string <= 1'b0;
    rst_ni                <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    while (items_sent < ITEM_TARGET) begin
      // switch between idling and full-rate stretches now and then
      if ($urandom_range(0, 39) == 0) calm <= ~calm;
      send_sequence();
    end
    // close any sequence left open so the last string is fully flushed
    send_byte(8'($urandom_range(0, 127)), 1'b1);
    byte_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d units", items_sent,
             sb.strings_ended, sb.units_checked);
    $display("Surrogate pairs: %0d, replacement units: %0d, errors: %0d",
             sb.pairs_made, sb.repl_made, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin : watchdog
    #3000000;
    $display("Timeout with %0d units still expected", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/u8u16_pkg.sv
src/u8u16_if.sv
src/u8u16_front.sv
src/u8u16_queue.sv
src/u8u16_back.sv
src/utf8_to_utf16_transcoder.sv
src/u8u16_checker.sv
tb/u8u16_scoreboard_pkg.sv
tb/utf8_to_utf16_transcoder_tb.sv
